// ===== src/text_console_writer_assert.svh =====
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge out of reset
`define TCW_ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("text console writer: assertion failed");
// implication into the next cycle
`define TCW_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("text console writer: assertion failed");
`else
`define TCW_ASSERT_HOLDS(lbl, clk, rstn, prop)
`define TCW_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

// ===== src/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] COLOR_RESET = 8'h0F;

    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_BS    = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } state_t;

    // finished result handed from the sequencer to the output register
    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] data;
    } res_t;

endpackage

`default_nettype wire

// ===== src/tcw_ram.sv =====
`default_nettype none

module tcw_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/tcw_ctrl.sv =====
`default_nettype none

module tcw_ctrl import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          in_func,
    input  wire logic [7:0]                          in_char,
    input  wire logic [4:0]                          in_row,
    input  wire logic [6:0]                          in_col,
    input  wire logic [7:0]                          color,
    output res_t                                     res,
    input  wire logic                                res_taken,
    output logic                                     mem_we,
    output logic      [$clog2(ROWS*COLUMNS)-1:0]     mem_waddr,
    output logic      [CELL_W-1:0]                   mem_wdata,
    output logic      [$clog2(ROWS*COLUMNS)-1:0]     mem_raddr,
    input  wire logic [CELL_W-1:0]                   mem_rdata
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int SUM_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic                pend_reg, pend_next;

    func_t               func_reg, func_next;
    logic [7:0]          char_reg, char_next;
    logic [4:0]          rrow_reg, rrow_next;
    logic [6:0]          rcol_reg, rcol_next;
    logic [ADDR_W-1:0]   src_reg, src_next;
    logic [ADDR_W-1:0]   dst_reg, dst_next;
    logic [CELL_W-1:0]   data_reg, data_next;

    logic                accept;
    logic                adv_row;
    logic [COL_W-1:0]    col_sel;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_in_range;
    logic [SUM_W-1:0]    pos_wide;
    logic [CELL_W-1:0]   blank_cell;
    logic [CELL_W-1:0]   char_cell;

    assign blank_cell = {color, CH_SPACE};
    assign char_cell  = {color, char_reg};

    assign cur_addr = base_reg + ADDR_W'(col_reg);
    // backspace writes one cell left of the cursor
    assign col_sel  = (func_reg == FUNC_BS) ? COL_W'(col_reg - 1'b1) : col_reg;
    assign wr_addr  = base_reg + ADDR_W'(col_sel);

    assign rd_in_range = (32'(rrow_reg) < 32'(ROWS)) && (32'(rcol_reg) < 32'(COLUMNS));
    assign rd_addr     = ADDR_W'(32'(rrow_reg) * 32'(COLUMNS) + 32'(rcol_reg));

    assign pos_wide = SUM_W'(cur_addr);

    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && res_taken);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        base_next  = base_reg;
        pend_next  = pend_reg;
        func_next  = func_reg;
        char_next  = char_reg;
        rrow_next  = rrow_reg;
        rcol_next  = rcol_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        data_next  = data_reg;
        adv_row    = 1'b0;

        mem_we    = 1'b0;
        mem_waddr = dst_reg;
        mem_wdata = blank_cell;
        mem_raddr = src_reg;

        res.valid = 1'b0;
        res.pos   = pos_wide[POS_W-1:0];
        res.data  = data_reg;

        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_EXEC: begin
                data_next  = '0;
                state_next = ST_DONE;
                unique case (func_reg)
                    FUNC_PUT: begin
                        if (char_reg == CH_NEWLINE) begin
                            adv_row = 1'b1;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = wr_addr;
                            mem_wdata = char_cell;
                            if (col_reg == LAST_COL) begin
                                adv_row = 1'b1;
                            end else begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                    end
                    FUNC_BS: begin
                        if (col_reg != '0) begin
                            col_next  = col_sel;
                            mem_we    = 1'b1;
                            mem_waddr = wr_addr;
                            mem_wdata = blank_cell;
                        end
                    end
                    FUNC_CLEAR: begin
                        row_next   = '0;
                        col_next   = '0;
                        base_next  = '0;
                        dst_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_FILL;
                    end
                    FUNC_READ: begin
                        if (rd_in_range) begin
                            mem_raddr  = rd_addr;
                            state_next = ST_READ;
                        end
                    end
                    default: begin
                    end
                endcase
                if (adv_row) begin
                    col_next = '0;
                    if (row_reg == LAST_ROW) begin
                        // scroll: copy rows up one, then blank the bottom row
                        src_next   = ROW_STEP;
                        dst_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_SCROLL;
                    end else begin
                        row_next  = row_reg + 1'b1;
                        base_next = base_reg + ROW_STEP;
                    end
                end
            end
            ST_READ: begin
                data_next  = mem_rdata;
                state_next = ST_DONE;
            end
            ST_SCROLL: begin
                mem_raddr = src_reg;
                pend_next = 1'b1;
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = mem_rdata;
                    dst_next  = dst_reg + 1'b1;
                end
                src_next = src_reg + 1'b1;
                if (src_reg == LAST_CELL) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                // a pending copy from the scroll drains first, then blanks
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                mem_wdata = pend_reg ? mem_rdata : blank_cell;
                pend_next = 1'b0;
                dst_next  = dst_reg + 1'b1;
                if (dst_reg == LAST_CELL) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                res.valid = 1'b1;
                if (res_taken) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (accept) begin
            func_next  = func_t'(in_func);
            char_next  = in_char;
            rrow_next  = in_row;
            rcol_next  = in_col;
            state_next = ST_EXEC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            base_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            base_reg  <= base_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        char_reg <= char_next;
        rrow_reg <= rrow_next;
        rcol_reg <= rcol_next;
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== src/text_console_writer.sv =====
// put/newline/backspace step through execute and done; a read cell adds a read state
// clear: one store write a cycle through the RAM's single write port
// a put or newline that scrolls: a read and a write per cell as the rows move up
// a new item is accepted only in idle, or in done as the last result is taken
// aresetn (sync, active low) homes the cursor and sets color_reg to 0x0F
// the cell store is not cleared by reset: a clear item must come first
`default_nettype none

`include "text_console_writer_assert.svh"

module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [7:0]  s_char_code,
    input  wire logic [4:0]  s_read_row,
    input  wire logic [6:0]  s_read_col,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [10:0]      m_cursor_pos,
    output logic [15:0]      m_read_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [7:0]        color_reg, color_next;
    logic              m_valid_reg, m_valid_next;
    logic [POS_W-1:0]  m_pos_reg, m_pos_next;
    logic [CELL_W-1:0] m_data_reg, m_data_next;

    res_t              res_st;
    logic              res_taken;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    assign cfg_ready = 1'b1;

    // output register takes a result when empty or being drained
    assign res_taken = res_st.valid && (!m_valid_reg || m_ready);

    always_comb begin
        color_next   = (cfg_valid && cfg_ready) ? cfg_data : color_reg;
        m_valid_next = res_taken ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_pos_next   = res_taken ? res_st.pos : m_pos_reg;
        m_data_next  = res_taken ? res_st.data : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg   <= COLOR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            color_reg   <= color_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_pos_reg  <= m_pos_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = m_pos_reg;
    assign m_read_data  = m_data_reg;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_func   (s_func),
        .in_char   (s_char_code),
        .in_row    (s_read_row),
        .in_col    (s_read_col),
        .color     (color_reg),
        .res       (res_st),
        .res_taken (res_taken),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tcw_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // after an accepted item the input is not ready in the next cycle
    `TCW_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a result that cannot move on blocks the input
    `TCW_ASSERT_HOLDS(a_no_accept_on_stall, aclk, aresetn, !(res_st.valid && !res_taken && s_ready))
    // the reported cursor always lies inside the store
    `TCW_ASSERT_HOLDS(a_cursor_in_store, aclk, aresetn, !m_valid || (32'(m_cursor_pos) < CELLS))

endmodule

`default_nettype wire
